### src/prle_pkg.sv
// ============================================================================
// PackBits run-length decoder package
// Shared types and constants for the decoder core.
// ============================================================================
`default_nettype none

package prle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned TOTAL_W = 17;

    localparam logic [SIZE_W-1:0] DEPACK_SIZE_RST = 16'd32000;

    // One decoded result.
    typedef struct packed {
        logic [BYTE_W-1:0] out_value;
        logic [BYTE_W-1:0] repeat_count;
        logic              last;
    } t_result;

    // Result handed from the decode stage to the output buffer.
    typedef struct packed {
        logic    vld;
        t_result res;
    } t_push;

endpackage

`default_nettype wire

### src/prle_if.sv
// ============================================================================
// PackBits decoder channel interfaces
// Valid/ready channels for compressed bytes, results and the size register.
// ============================================================================
`default_nettype none

interface prle_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink   (input valid, input src_byte, output ready);
endinterface

interface prle_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic [7:0] repeat_count;
    logic       last;

    modport source (output valid, output out_value, output repeat_count, output last,
                    input ready);
    modport sink   (input valid, input out_value, input repeat_count, input last,
                    output ready);
endinterface

interface prle_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] depack_size;

    modport source (output valid, output depack_size, input ready);
    modport sink   (input valid, input depack_size, output ready);
endinterface

`default_nettype wire

### src/packbits_rle_decoder_core.sv
// ============================================================================
// PackBits run-length decoder core
// Decodes a compressed byte stream into (value, repeat count, last) requests.
// ============================================================================
// Output: a result is registered in the output register or the skid entry
//   before it shows on o_res; header bytes are absorbed and produce nothing.
// Throughput: one compressed byte per cycle while the skid entry is free, set
//   by the state update in the decode stage; a one-entry skid keeps input
//   flowing while a result waits to be taken, and input stalls once it is full.
// Reset: synchronous, active low; the decoder waits for a header, the image
//   total clears and the image size returns to 32000.
`default_nettype none

module packbits_rle_decoder_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    prle_src_if.sink   i_src,
    prle_res_if.source o_res,
    prle_cfg_if.sink   i_cfg
);
    import prle_pkg::*;

    logic    w_accept;
    logic    w_ready;
    logic    w_valid;
    logic    w_pop;
    t_push   w_push;
    t_result w_res;

    // Size reg always writable; user must write it while core idle; unchecked.
    assign i_cfg.ready = 1'b1;

    assign i_src.ready = w_ready;
    assign w_accept    = i_src.valid && w_ready;
    assign w_pop       = o_res.ready;

    // Decode stage: tracks the group phase and the running image total, and
    // turns each literal or run data byte into one request.
    prle_dec u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_byte     (i_src.src_byte),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_size (i_cfg.depack_size),
        .o_push     (w_push)
    );

    // Output register plus skid entry, so a stalled consumer does not stall
    // the byte in flight.
    prle_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_ready (w_ready),
        .o_valid (w_valid),
        .o_res   (w_res)
    );

    assign o_res.valid        = w_valid;
    assign o_res.out_value    = w_res.out_value;
    assign o_res.repeat_count = w_res.repeat_count;
    assign o_res.last         = w_res.last;

    // A request is only formed from an accepted byte.
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.vld |-> w_accept)
        else $error("request formed without an accepted byte");

    // After every request the output holds a valid result in the next cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.vld |=> o_res.valid)
        else $error("request lost after decode");

    // A stalled input implies a result is waiting at the output.
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_src.ready |-> o_res.valid)
        else $error("input stalled with empty output");

    // Requests never carry a zero repeat count.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.vld |-> (w_push.res.repeat_count != 8'd0))
        else $error("zero repeat count");

endmodule

`default_nettype wire

### src/prle_dec.sv
// ============================================================================
// PackBits decode stage
// Group state, image total and size register; forms one result per data byte.
// ============================================================================
`default_nettype none

module prle_dec (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [prle_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                         i_cfg_we,
    input  wire logic [prle_pkg::SIZE_W-1:0]  i_cfg_size,
    output prle_pkg::t_push                   o_push
);
    import prle_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_RUN     = 2'd2;

    logic [1:0]         r_phase,   n_phase;
    logic [BYTE_W-1:0]  r_lit,     n_lit;
    logic [BYTE_W-1:0]  r_run,     n_run;
    logic [TOTAL_W-1:0] r_total,   n_total;
    logic [SIZE_W-1:0]  r_size;

    logic [BYTE_W-1:0]  lit_m1;
    logic [BYTE_W-1:0]  add_val;
    logic [TOTAL_W-1:0] sum;
    logic [BYTE_W:0]    run_calc;
    logic               done;

    always_comb begin
        lit_m1   = r_lit - 8'd1;
        add_val  = (r_phase == PH_RUN) ? r_run : 8'd1;
        sum      = r_total + {{(TOTAL_W-BYTE_W){1'b0}}, add_val};
        done     = (sum >= {{(TOTAL_W-SIZE_W){1'b0}}, r_size});
        run_calc = 9'd257 - {1'b0, i_byte};

        n_phase = r_phase;
        n_lit   = r_lit;
        n_run   = r_run;
        n_total = r_total;
        o_push  = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_LITERAL: begin
                    o_push.vld              = 1'b1;
                    o_push.res.out_value    = i_byte;
                    o_push.res.repeat_count = 8'd1;
                    n_lit                   = lit_m1;
                    if (lit_m1 == '0) begin
                        n_phase         = PH_HEADER;
                        o_push.res.last = done;
                        n_total         = done ? '0 : sum;
                    end else begin
                        n_total = sum;
                    end
                end
                PH_RUN: begin
                    o_push.vld              = 1'b1;
                    o_push.res.out_value    = i_byte;
                    o_push.res.repeat_count = r_run;
                    o_push.res.last         = done;
                    n_phase                 = PH_HEADER;
                    n_total                 = done ? '0 : sum;
                end
                default: begin
                    // Header byte; the unused phase code is read as a header too.
                    if (!i_byte[BYTE_W-1]) begin
                        n_lit   = {1'b0, i_byte[BYTE_W-2:0]} + 8'd1;
                        n_phase = PH_LITERAL;
                    end else begin
                        n_run   = run_calc[BYTE_W-1:0];
                        n_phase = PH_RUN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_lit   <= '0;
            r_run   <= '0;
            r_total <= '0;
            r_size  <= DEPACK_SIZE_RST;
        end else begin
            r_phase <= n_phase;
            r_lit   <= n_lit;
            r_run   <= n_run;
            r_total <= n_total;
            if (i_cfg_we) begin
                r_size <= i_cfg_size;
            end
        end
    end

endmodule

`default_nettype wire

### src/prle_obuf.sv
// ============================================================================
// PackBits output buffer
// Result register with one skid entry behind it.
// ============================================================================
`default_nettype none

module prle_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire prle_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output logic                  o_ready,
    output logic                  o_valid,
    output prle_pkg::t_result     o_res
);
    import prle_pkg::*;

    logic    r_out_v, n_out_v;
    logic    r_skd_v, n_skd_v;
    t_result r_out,   n_out;
    t_result r_skd,   n_skd;
    logic    pop;

    always_comb begin
        pop     = i_pop && r_out_v;
        n_out_v = r_out_v;
        n_skd_v = r_skd_v;
        n_out   = r_out;
        n_skd   = r_skd;
        if (r_skd_v) begin
            // No new request can arrive while the skid entry is occupied.
            if (pop) begin
                n_out   = r_skd;
                n_skd_v = 1'b0;
            end
        end else if (!r_out_v || pop) begin
            n_out   = i_push.res;
            n_out_v = i_push.vld;
        end else if (i_push.vld) begin
            n_skd   = i_push.res;
            n_skd_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
            r_skd_v <= n_skd_v;
        end
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_ready = !r_skd_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

`default_nettype wire

### tb/testbench.sv
// ============================================================================
// PackBits run-length decoder testbench
// Streams directed and random compressed groups into the decoder core, runs a
// byte-level decoder model alongside it and checks every request that comes out.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    import prle_pkg::*;

    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned SETTLE       = 4;      // settle time at the end of drain()
    localparam int unsigned QUIET_LIMIT  = 3000;   // above the longest hold-off plus the longest gaps
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_FIRST   = 150;
    localparam int unsigned HOLD_SECOND  = 700;

    typedef enum logic [1:0] {
        HDR_WAIT,
        LIT_BYTES,
        RUN_BYTE
    } t_dec_phase;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    prle_src_if src_if ();
    prle_res_if res_if ();
    prle_cfg_if cfg_if ();

    packbits_rle_decoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_src   (src_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Decoder state as it should be after every accepted byte.
    t_dec_phase        dec_phase;
    logic [7:0]        lit_left;
    logic [7:0]        run_len;
    logic [16:0]       img_total;
    logic [SIZE_W-1:0] img_size;

    logic [7:0] byte_queue[$];
    t_result    expected_requests[$];

    bit          src_idle_en = 1'b1;
    bit          res_idle_en = 1'b1;
    int unsigned feed_wait;
    int unsigned sink_wait;
    int unsigned hold_left;
    int unsigned requests_taken;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned bytes_in;
    int unsigned runs_seen;
    int unsigned literals_seen;
    int unsigned image_ends;
    int unsigned size_writes;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Closes a group: adds its last contribution and tells whether the image is done.
    function automatic logic close_group(input logic [16:0] added);
        img_total = img_total + added;
        dec_phase = HDR_WAIT;
        if (img_total >= {1'b0, img_size}) begin
            img_total = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the decoder by one byte; returns 1 when the byte yields a request.
    function automatic bit decode_byte(input logic [7:0] b, output t_result req);
        bit produced;
        produced = 1'b0;
        req = '0;
        case (dec_phase)
            LIT_BYTES: begin
                req.out_value    = b;
                req.repeat_count = 8'd1;
                lit_left = lit_left - 8'd1;
                if (lit_left == 8'd0) begin
                    req.last = close_group(17'd1);
                end else begin
                    img_total = img_total + 17'd1;
                end
                produced = 1'b1;
            end
            RUN_BYTE: begin
                req.out_value    = b;
                req.repeat_count = run_len;
                req.last         = close_group({9'd0, run_len});
                produced = 1'b1;
            end
            default: begin
                // Header: 0..127 opens a literal group, a negative value a run.
                if (b < 8'h80) begin
                    lit_left  = b + 8'd1;
                    dec_phase = LIT_BYTES;
                end else begin
                    run_len   = 8'(9'd257 - {1'b0, b});
                    dec_phase = RUN_BYTE;
                end
            end
        endcase
        return produced;
    endfunction

    // Byte feeder.
    always @(posedge clk) begin
        if (!rst_n) begin
            src_if.valid    <= 1'b0;
            src_if.src_byte <= '0;
            feed_wait = 0;
        end else if (!src_if.valid || src_if.ready) begin
            if (feed_wait > 0) begin
                feed_wait--;
                src_if.valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                src_if.src_byte <= byte_queue.pop_front();
                src_if.valid    <= 1'b1;
                feed_wait = src_idle_en ? pick_gap() : 0;
            end else begin
                src_if.valid <= 1'b0;
            end
        end
    end

    // Request sink. Twice in the run it stops taking requests for a long
    // stretch so that the core backs up and pushes back on its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            sink_wait = 0;
            hold_left = 0;
            requests_taken = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                requests_taken++;
                if (requests_taken == HOLD_FIRST || requests_taken == HOLD_SECOND) begin
                    hold_left = HOLD_CYCLES;
                end else if (res_idle_en) begin
                    sink_wait = pick_gap();
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: checks requests, tracks accepted bytes and size writes, and
    // ends the run if nothing moves for too long.
    always @(posedge clk) begin : monitor
        t_result seen;
        t_result want;
        t_result predicted;
        bit      moved;
        if (!rst_n) begin
            dec_phase = HDR_WAIT;
            lit_left  = '0;
            run_len   = '0;
            img_total = '0;
            img_size  = DEPACK_SIZE_RST;
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                seen.out_value    = res_if.out_value;
                seen.repeat_count = res_if.repeat_count;
                seen.last         = res_if.last;
                if (expected_requests.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected request value %0d count %0d last %0b",
                             $time, seen.out_value, seen.repeat_count, seen.last);
                end else begin
                    want = expected_requests.pop_front();
                    if (seen.out_value !== want.out_value) begin
                        errors++;
                        $display("%0t: out_value expected %0d, got %0d",
                                 $time, want.out_value, seen.out_value);
                    end
                    if (seen.repeat_count !== want.repeat_count) begin
                        errors++;
                        $display("%0t: repeat_count expected %0d, got %0d",
                                 $time, want.repeat_count, seen.repeat_count);
                    end
                    if (seen.last !== want.last) begin
                        errors++;
                        $display("%0t: last expected %0b, got %0b",
                                 $time, want.last, seen.last);
                    end
                    if (want.repeat_count > 8'd1) runs_seen++;
                    else literals_seen++;
                    if (want.last) image_ends++;
                end
            end
            if (src_if.valid && src_if.ready) begin
                moved = 1'b1;
                bytes_in++;
                if (decode_byte(src_if.src_byte, predicted)) begin
                    expected_requests.push_back(predicted);
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                size_writes++;
                img_size = cfg_if.depack_size;
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no traffic for %0d cycles, %0d requests outstanding",
                             $time, quiet_cycles, expected_requests.size());
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    task automatic feed(input logic [7:0] b);
        byte_queue.push_back(b);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        @(posedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.depack_size <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Waits until every byte is taken and every request has come back.
    task automatic drain();
        do @(posedge clk);
        while (byte_queue.size() != 0 || src_if.valid || expected_requests.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly well-formed groups with random contents, plus some stray headers
    // that throw the stream out of step.
    task automatic add_random_groups(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned pick;
        int unsigned hdr;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                feed(8'($urandom_range(0, 255)));
                sent += 1;
            end else if (pick < 55) begin
                if (pick == 5) hdr = 127;
                else if (pick < 8) hdr = $urandom_range(8, 127);
                else hdr = $urandom_range(0, 7);
                feed(8'(hdr));
                repeat (hdr + 1) feed(8'($urandom_range(0, 255)));
                sent += hdr + 2;
            end else begin
                hdr = (pick < 92) ? $urandom_range(8'h80, 8'hFF) : 8'h80;
                feed(8'(hdr));
                feed(8'($urandom_range(0, 255)));
                sent += 2;
            end
        end
    endtask

    initial begin
        cfg_if.valid       = 1'b0;
        cfg_if.depack_size = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size: single literal, a run of 129 from the minus 128 header,
        // the shortest run, a run of 128 and a two-byte literal group.
        feed(8'h00); feed(8'h11);
        feed(8'h80); feed(8'hFF);
        feed(8'hFF); feed(8'h00);
        feed(8'h81); feed(8'hAA);
        feed(8'h01); feed(8'hF0); feed(8'h0F);
        drain();

        // Size 5: the image completes inside an eight-byte literal group, so
        // only its final byte is marked; then a run and a literal pair land
        // exactly on the size.
        write_size(16'd5);
        feed(8'h07);
        feed(8'h01); feed(8'h02); feed(8'h04); feed(8'h08);
        feed(8'h10); feed(8'h20); feed(8'h40); feed(8'h80);
        feed(8'hFE); feed(8'h33);
        feed(8'h01); feed(8'hC3); feed(8'h3C);
        drain();

        // A size of zero marks the end of every group.
        write_size(16'd0);
        add_random_groups(200);
        drain();

        write_size(16'd1);
        add_random_groups(200);
        drain();

        // Largest size, with both sides running flat out.
        src_idle_en = 1'b0;
        res_idle_en = 1'b0;
        write_size(16'hFFFF);
        add_random_groups(250);
        drain();
        src_idle_en = 1'b1;
        res_idle_en = 1'b1;

        write_size(16'($urandom_range(2, 400)));
        add_random_groups(300);
        drain();

        write_size(16'($urandom_range(1, 65535)));
        add_random_groups(250);
        drain();

        write_size(16'd100);
        add_random_groups(300);
        drain();

        write_size(DEPACK_SIZE_RST);
        add_random_groups(250);
        drain();

        $display("Covered %0d compressed bytes giving %0d runs and %0d literals, %0d image ends.",
                 bytes_in, runs_seen, literals_seen, image_ends);
        $display("Image size written %0d times, from zero up to 65535, with two long sink stalls.",
                 size_writes);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
